@@ rtl/max_collinear_points_macros.svh @@
// Assertion macros for the max_collinear_points block.
// Included by the RTL files that check their own logic; depends on nothing else.
`ifndef MAX_COLLINEAR_POINTS_MACROS_SVH
`define MAX_COLLINEAR_POINTS_MACROS_SVH
`ifndef SYNTHESIS
`define MCP_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");
`define MCP_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define MCP_ASSERT_IMP(label, ante, cons)
`define MCP_ASSERT_NXT(label, ante, cons)
`endif
`endif

@@ rtl/mcp_pkg.sv @@
// Shared types and codes for the max_collinear_points block.
// Used by the slope reduction unit and the top level; depends on nothing.
package mcp_pkg;
   typedef logic [3:0] seq_state_type;
   typedef logic [1:0] canon_state_type;
   localparam logic ACTION_LOAD   = 1'b0;
   localparam logic ACTION_FINISH = 1'b1;
endpackage

@@ rtl/mcp_canon.sv @@
// Slope reduction unit: divides a direction by its gcd (binary gcd, then
// restoring division of both parts one bit per cycle). Depends on mcp_pkg.
module mcp_canon import mcp_pkg::*; #(
   parameter int UW = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [UW-1:0]        ax,
   input  logic [UW-1:0]        ay,
   input  logic                 neg,
   output logic                 done,
   output logic signed [UW:0]   sx,
   output logic [UW-1:0]        sy
);
   localparam int KW = $clog2(UW + 1);
   localparam canon_state_type C_IDLE = 2'd0;
   localparam canon_state_type C_TWO  = 2'd1;
   localparam canon_state_type C_RED  = 2'd2;
   localparam canon_state_type C_DIV  = 2'd3;

   canon_state_type state_ff, state_in;
   logic [UW-1:0] a_ff, a_in, b_ff, b_in, g_ff, g_in;
   logic [UW-1:0] na_ff, na_in, nb_ff, nb_in;
   logic [UW-1:0] ra_ff, ra_in, rb_ff, rb_in;
   logic [KW-1:0] k_ff, k_in, cnt_ff, cnt_in;
   logic          neg_ff, neg_in, done_ff, done_in;
   logic [UW:0]   ta, tb;

   always_comb begin
      state_in = state_ff;
      a_in = a_ff; b_in = b_ff; g_in = g_ff; k_in = k_ff; cnt_in = cnt_ff;
      na_in = na_ff; nb_in = nb_ff; ra_in = ra_ff; rb_in = rb_ff;
      neg_in = neg_ff; done_in = 1'b0;
      ta = {ra_ff, na_ff[UW-1]};
      tb = {rb_ff, nb_ff[UW-1]};
      case (state_ff)
         C_IDLE: begin
            if (start) begin
               a_in = ax; b_in = ay; na_in = ax; nb_in = ay; neg_in = neg;
               k_in = '0; state_in = C_TWO;
            end
         end
         C_TWO: begin
            if (!a_ff[0] && !b_ff[0]) begin
               a_in = a_ff >> 1; b_in = b_ff >> 1; k_in = k_ff + 1'b1;
            end else begin
               state_in = C_RED;
            end
         end
         C_RED: begin
            if (a_ff == '0) begin
               g_in = b_ff << k_ff;
               ra_in = '0; rb_in = '0;
               cnt_in = KW'(UW);
               state_in = C_DIV;
            end else if (!a_ff[0]) begin
               a_in = a_ff >> 1;
            end else if (!b_ff[0]) begin
               b_in = b_ff >> 1;
            end else if (a_ff >= b_ff) begin
               a_in = (a_ff - b_ff) >> 1;
            end else begin
               b_in = (b_ff - a_ff) >> 1;
            end
         end
         C_DIV: begin
            if (ta >= {1'b0, g_ff}) begin
               ra_in = UW'(ta - {1'b0, g_ff}); na_in = {na_ff[UW-2:0], 1'b1};
            end else begin
               ra_in = ta[UW-1:0]; na_in = {na_ff[UW-2:0], 1'b0};
            end
            if (tb >= {1'b0, g_ff}) begin
               rb_in = UW'(tb - {1'b0, g_ff}); nb_in = {nb_ff[UW-2:0], 1'b1};
            end else begin
               rb_in = tb[UW-1:0]; nb_in = {nb_ff[UW-2:0], 1'b0};
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == KW'(1)) begin
               done_in = 1'b1; state_in = C_IDLE;
            end
         end
         default: state_in = C_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      a_ff <= a_in; b_ff <= b_in; g_ff <= g_in; k_ff <= k_in; cnt_ff <= cnt_in;
      na_ff <= na_in; nb_ff <= nb_in; ra_ff <= ra_in; rb_ff <= rb_in; neg_ff <= neg_in;
   end

   assign done = done_ff;
   assign sx   = neg_ff ? -$signed({1'b0, na_ff}) : $signed({1'b0, na_ff});
   assign sy   = nb_ff;
endmodule

@@ rtl/max_collinear_points.sv @@
// Top level of the max_collinear_points block: point store, slope table and
// pair sequencer. Depends on mcp_pkg, mcp_canon and the assertion macros.
//
// Load items (tuser 0) each write one point into the point store; points
// beyond MAX_POINTS are dropped and reported with the result. A finish item
// (tuser 1) starts the pair walk, or for sets of up to two points skips it,
// and returns one result item. For every origin i and later point j the walk
// reads and dispatches the pair; unless j repeats the origin, it runs the
// binary gcd loop and bit-serial division of the slope unit when neither part
// of the direction is zero, then searches the slope table entry by entry (the
// table holds the distinct slopes seen so far from this origin, one read port).
// Input is accepted only while the sequencer is idle; a result waiting on the
// output register does not block loads of the next set.
`include "max_collinear_points_macros.svh"
module max_collinear_points import mcp_pkg::*; #(
   parameter int MAX_POINTS  = 256,
   parameter int COORD_WIDTH = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // Fields from bit 0: point_x, point_y.
   input  logic [((2*COORD_WIDTH+7)/8)*8-1:0] req_tdata,
   // Fields from bit 0: action.
   input  logic req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // Fields from bit 0: max_on_line, overflowed.
   output logic [(($clog2(MAX_POINTS+1)+1+7)/8)*8-1:0] rsp_tdata
);
   localparam int W     = COORD_WIDTH;
   localparam int CW    = $clog2(MAX_POINTS + 1);
   localparam int IW    = $clog2(MAX_POINTS);
   localparam int RSP_W = ((CW + 1 + 7) / 8) * 8;
   localparam int SW    = (W + 1) + W + CW;

   localparam seq_state_type S_IDLE = 4'd0;
   localparam seq_state_type S_RDI  = 4'd1;
   localparam seq_state_type S_LDI  = 4'd2;
   localparam seq_state_type S_NXT  = 4'd3;
   localparam seq_state_type S_RDJ  = 4'd4;
   localparam seq_state_type S_LDJ  = 4'd5;
   localparam seq_state_type S_CAN  = 4'd6;
   localparam seq_state_type S_SRCH = 4'd7;
   localparam seq_state_type S_CMP  = 4'd8;
   localparam seq_state_type S_OUT  = 4'd9;

   // Point store and slope table (slope x, slope y, tally).
   logic [2*W-1:0] pt_mem [MAX_POINTS];
   logic [SW-1:0]  sl_mem [MAX_POINTS];
   logic [2*W-1:0] pt_rd_ff;
   logic [SW-1:0]  sl_rd_ff;

   seq_state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in, i_ff, i_in, j_ff, j_in;
   logic [CW-1:0] dup_ff, dup_in, top_ff, top_in, best_ff, best_in;
   logic [IW-1:0] k_ff, k_in, used_ff, used_in;
   logic          ovf_ff, ovf_in;
   logic signed [W-1:0] px_ff, px_in, py_ff, py_in;
   logic signed [W:0]   sx_ff, sx_in;
   logic [W-1:0]        sy_ff, sy_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [CW:0]   rsp_data_ff, rsp_data_in;

   logic          pt_we, sl_we, can_start, can_done;
   logic [IW-1:0] pt_ra, sl_ra, sl_wa;
   logic [SW-1:0] sl_wd;
   logic signed [W:0]   dx, dy, can_sx;
   logic [W-1:0]        ax, ay, can_sy;
   logic [CW-1:0]       tally_rd, tally_new, cand;
   logic signed [W-1:0] jx, jy;

   assign jx = pt_rd_ff[W-1:0];
   assign jy = pt_rd_ff[2*W-1:W];
   assign dx = $signed({jx[W-1], jx}) - $signed({px_ff[W-1], px_ff});
   assign dy = $signed({jy[W-1], jy}) - $signed({py_ff[W-1], py_ff});
   assign ax = dx[W] ? W'(-dx) : dx[W-1:0];
   assign ay = dy[W] ? W'(-dy) : dy[W-1:0];
   assign tally_rd  = sl_rd_ff[CW-1:0];
   assign tally_new = tally_rd + 1'b1;
   assign cand      = top_ff + dup_ff;

   mcp_canon #(.UW(W)) u_canon (
      .clock (clock),
      .reset (reset),
      .start (can_start),
      .ax    (ax),
      .ay    (ay),
      .neg   (dx[W] ^ dy[W]),
      .done  (can_done),
      .sx    (can_sx),
      .sy    (can_sy)
   );

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff; ovf_in = ovf_ff;
      i_in = i_ff; j_in = j_ff; k_in = k_ff; used_in = used_ff;
      dup_in = dup_ff; top_in = top_ff; best_in = best_ff;
      px_in = px_ff; py_in = py_ff; sx_in = sx_ff; sy_in = sy_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      pt_we = 1'b0; pt_ra = i_ff[IW-1:0];
      sl_we = 1'b0; sl_wa = k_ff; sl_wd = {sx_ff, sy_ff, tally_new}; sl_ra = k_ff;
      can_start = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser == ACTION_LOAD) begin
                  if (count_ff < CW'(MAX_POINTS)) begin
                     pt_we = 1'b1; count_in = count_ff + 1'b1;
                  end else begin
                     ovf_in = 1'b1;
                  end
               end else if (count_ff <= CW'(2)) begin
                  best_in = count_ff; state_in = S_OUT;
               end else begin
                  best_in = CW'(1); i_in = '0; state_in = S_RDI;
               end
            end
         end
         S_RDI: begin
            pt_ra = i_ff[IW-1:0]; state_in = S_LDI;
         end
         S_LDI: begin
            // Origin point is in; start a fresh slope table for it.
            px_in = jx; py_in = jy;
            j_in = i_ff + 1'b1; used_in = '0; dup_in = CW'(1); top_in = '0;
            state_in = S_NXT;
         end
         S_NXT: begin
            if (j_ff == count_ff) begin
               if (cand > best_ff) best_in = cand;
               if (i_ff + 1'b1 == count_ff - 1'b1) begin
                  state_in = S_OUT;
               end else begin
                  i_in = i_ff + 1'b1; state_in = S_RDI;
               end
            end else begin
               state_in = S_RDJ;
            end
         end
         S_RDJ: begin
            pt_ra = j_ff[IW-1:0]; state_in = S_LDJ;
         end
         S_LDJ: begin
            k_in = '0;
            if (dx == '0 && dy == '0) begin
               dup_in = dup_ff + 1'b1; j_in = j_ff + 1'b1; state_in = S_NXT;
            end else if (dx == '0) begin
               sx_in = '0; sy_in = W'(1); state_in = S_SRCH;
            end else if (dy == '0) begin
               sx_in = (W+1)'(1); sy_in = '0; state_in = S_SRCH;
            end else begin
               can_start = 1'b1; state_in = S_CAN;
            end
         end
         S_CAN: begin
            if (can_done) begin
               sx_in = can_sx; sy_in = can_sy; state_in = S_SRCH;
            end
         end
         S_SRCH: begin
            if (k_ff == used_ff) begin
               // New slope for this origin: tally starts at one.
               sl_we = 1'b1; sl_wa = used_ff; sl_wd = {sx_ff, sy_ff, CW'(1)};
               used_in = used_ff + 1'b1;
               if (top_ff == '0) top_in = CW'(1);
               j_in = j_ff + 1'b1; state_in = S_NXT;
            end else begin
               sl_ra = k_ff; state_in = S_CMP;
            end
         end
         S_CMP: begin
            if (sl_rd_ff[SW-1:CW] == {sx_ff, sy_ff}) begin
               sl_we = 1'b1; sl_wa = k_ff;
               if (tally_new > top_ff) top_in = tally_new;
               j_in = j_ff + 1'b1; state_in = S_NXT;
            end else begin
               k_in = k_ff + 1'b1; state_in = S_SRCH;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1; rsp_data_in = {ovf_ff, best_ff};
               count_in = '0; ovf_in = 1'b0; state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         best_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         best_ff      <= best_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      i_ff <= i_in; j_ff <= j_in; k_ff <= k_in; used_ff <= used_in;
      dup_ff <= dup_in; top_ff <= top_in;
      px_ff <= px_in; py_ff <= py_in; sx_ff <= sx_in; sy_ff <= sy_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (pt_we) pt_mem[count_ff[IW-1:0]] <= req_tdata[2*W-1:0];
      pt_rd_ff <= pt_mem[pt_ra];
   end

   always_ff @(posedge clock) begin
      if (sl_we) sl_mem[sl_wa] <= sl_wd;
      sl_rd_ff <= sl_mem[sl_ra];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'(rsp_data_ff);

   `MCP_ASSERT_IMP(a_count_cap, 1'b1, count_ff <= CW'(MAX_POINTS))
   `MCP_ASSERT_IMP(a_rsp_from_out, $rose(rsp_valid_ff), $past(state_ff) == S_OUT)
   `MCP_ASSERT_IMP(a_search_bound, state_ff == S_SRCH, k_ff <= used_ff)
   `MCP_ASSERT_IMP(a_best_bound, state_ff == S_OUT, best_ff <= count_ff)
   `MCP_ASSERT_NXT(a_canon_wait, state_ff == S_LDJ && can_start, state_ff == S_CAN)
endmodule
